// ===== rtl/core/sqe_pkg.sv =====
package sqe_pkg;

   localparam int BATCH_SIZE = 256;
   localparam int ANGLE_BITS = 16;

   // Angle bits below the kept precision are cleared before the lookup.
   localparam logic [15:0] ANGLE_MASK = 16'((32'hFFFF << (16 - ANGLE_BITS)) & 32'hFFFF);
   localparam logic [15:0] QUARTER_TURN = 16'h4000;

   // Result order within one sprite: four corners, then two triangles.
   localparam logic [2:0] RES_V0 = 3'd0;
   localparam logic [2:0] RES_V1 = 3'd1;
   localparam logic [2:0] RES_V2 = 3'd2;
   localparam logic [2:0] RES_V3 = 3'd3;
   localparam logic [2:0] RES_T0 = 3'd4;
   localparam logic [2:0] RES_T1 = 3'd5;

   localparam logic KIND_VERTEX   = 1'b0;
   localparam logic KIND_TRIANGLE = 1'b1;

   localparam int SCL_W  = 33;  // vector times scale
   localparam int PROD_W = 49;  // scaled vector times sin or cos
   localparam int ROT_W  = 50;  // rotated right or up
   localparam int CRN_W  = 51;  // right plus or minus up

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] tan_x;
      logic signed [15:0] tan_y;
      logic signed [15:0] tan_z;
      logic signed [15:0] nrm_x;
      logic signed [15:0] nrm_y;
      logic signed [15:0] nrm_z;
      logic [15:0]        scale_factor;
      logic [15:0]        angle;
      logic               list_end;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
      logic               tex_u;
      logic               tex_v;
      logic [9:0]         idx_a;
      logic [9:0]         idx_b;
      logic [9:0]         idx_c;
      logic               batch_last;
      logic               last;
   } rsp_type;

   // Corner coordinate: position in Q.36 plus offset, rounded to Q.8, saturated.
   function automatic logic signed [31:0] corner_f(input logic signed [31:0] pos,
                                                   input logic signed [CRN_W-1:0] ofs);
      logic signed [63:0] acc;
      logic signed [63:0] shf;
      acc = $signed({{4{pos[31]}}, pos, 28'd0}) + 64'(ofs) + 64'sd134217728;
      shf = acc >>> 28;
      if (shf > 64'sd2147483647) begin
         corner_f = 32'sh7FFFFFFF;
      end else if (shf < -64'sd2147483648) begin
         corner_f = 32'sh80000000;
      end else begin
         corner_f = shf[31:0];
      end
   endfunction

endpackage

// ===== rtl/core/sqe_qsin.sv =====
module sqe_qsin (
   input  logic               clock,
   input  logic               en,
   input  logic [14:0]        t,
   input  logic               neg,
   output logic signed [15:0] val
);
   import sqe_pkg::*;

   logic [14:0] t1_ff, t2_ff, t3_ff;
   logic [14:0] sq1_ff, sq2_ff;
   logic        n1_ff, n2_ff, n3_ff;
   logic [13:0] mid2_ff;
   logic [14:0] outer3_ff;
   logic signed [15:0] val_ff;

   logic [29:0] sq_full;
   logic [25:0] inner_full;
   logic [28:0] mid2_full;
   logic [29:0] r_full;
   logic [14:0] r_cap;

   // The polynomial is a chain of four products, one per stage.
   assign sq_full    = 30'(t) * 30'(t);
   assign inner_full = 26'(sq1_ff) * 26'(11'd1160);
   assign mid2_full  = 29'(mid2_ff) * 29'(sq2_ff);
   assign r_full     = 30'(outer3_ff) * 30'(t3_ff);
   assign r_cap      = (r_full[29:14] > 16'd16384) ? 15'd16384 : r_full[28:14];

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff     <= t;
         sq1_ff    <= sq_full[28:14];
         n1_ff     <= neg;
         t2_ff     <= t1_ff;
         sq2_ff    <= sq1_ff;
         n2_ff     <= n1_ff;
         mid2_ff   <= 14'(14'd10512 - inner_full[24:14]);
         t3_ff     <= t2_ff;
         n3_ff     <= n2_ff;
         outer3_ff <= 15'(15'd25736 - 15'(mid2_full[28:14]));
         val_ff    <= n3_ff ? -$signed({1'b0, r_cap}) : $signed({1'b0, r_cap});
      end
   end

   assign val = val_ff;

endmodule

// ===== rtl/core/sprite_quad_expander.sv =====
// Billboard quad expander. Each transaction on the req_ channel carries one
// sprite: position, unit tangent and normal, scale and a rotation angle. For
// every sprite the block delivers six transactions on the rsp_ channel: the
// four quad corners with their texture coordinates, then the two triangles
// that index them within the current batch. The slot within the batch
// advances with each sprite and returns to zero after the batch's last slot
// or after a sprite flagged as the end of the list.
// The first result is presented after the sprite has passed the pipeline
// stages, the expander and the result register; the other five results
// follow at one result per cycle when the receiver does not stall; the
// single result register sets the throughput. The arithmetic runs in an
// eight stage pipeline with a valid bit per stage. When rsp_stall is high
// and a result waits, the result register holds, the expander holds its
// sprite, and the pipeline stops once its last stage is full; req_stall
// then rises. Nothing is dropped or repeated. Synchronous reset empties the
// pipeline and the result register and clears the slot counter.
module sprite_quad_expander (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sqe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sqe_pkg::rsp_type rsp_data
);
   import sqe_pkg::*;

   localparam int NST = 8;

   logic               vld_ff [0:NST-1];
   logic signed [31:0] pos_ff [0:NST-1][0:2];
   logic [9:0]         base_ff [0:NST-1];
   logic               blast_ff [0:NST-1];

   // Stage 0 holds the raw vectors and angle.
   logic signed [15:0] tan_ff [0:2];
   logic signed [15:0] nrm_ff [0:2];
   logic [15:0]        scl_ff;
   logic [15:0]        ang_ff;

   // Scaled vectors, computed in stage 1 and carried to stage 4.
   logic signed [SCL_W-1:0] rgt_ff [1:4][0:2];
   logic signed [SCL_W-1:0] up_ff  [1:4][0:2];

   logic signed [PROD_W-1:0] rc_ff [0:2];
   logic signed [PROD_W-1:0] us_ff [0:2];
   logic signed [PROD_W-1:0] rs_ff [0:2];
   logic signed [PROD_W-1:0] uc_ff [0:2];
   logic signed [ROT_W-1:0]  rr_ff [0:2];
   logic signed [ROT_W-1:0]  ru_ff [0:2];
   logic signed [CRN_W-1:0]  sum_ff [0:2];
   logic signed [CRN_W-1:0]  dif_ff [0:2];

   logic               ex_vld_ff;
   logic [2:0]         ex_cnt_ff;
   logic signed [31:0] ex_pos_ff [0:2];
   logic signed [CRN_W-1:0] ex_sum_ff [0:2];
   logic signed [CRN_W-1:0] ex_dif_ff [0:2];
   logic [9:0]         ex_base_ff;
   logic               ex_blast_ff;

   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   logic [7:0]         slot_ff;
   logic [7:0]         slot_in;
   logic               blast_in;

   logic               en;
   logic               accept;
   logic               out_load;
   logic               ex_fire;
   logic               ex_done;
   logic               take;

   logic [15:0]        sin_ph;
   logic [15:0]        cos_ph;
   logic [14:0]        sin_t;
   logic [14:0]        cos_t;
   logic signed [15:0] sin_val;
   logic signed [15:0] cos_val;

   // Flow control: the result register loads whenever it is empty or being
   // taken; the expander sends one result per load; the pipeline moves
   // whenever its last stage is empty or handing its sprite to the expander.
   assign out_load = !rsp_valid_ff || !rsp_stall;
   assign ex_fire  = ex_vld_ff && out_load;
   assign ex_done  = ex_fire && (ex_cnt_ff == RES_T1);
   assign take     = vld_ff[NST-1] && (!ex_vld_ff || ex_done);
   assign en       = !vld_ff[NST-1] || take;
   assign accept   = req_valid && en;
   assign req_stall = !en;

   // The slot is assigned at acceptance, so it follows the input order.
   assign blast_in = req_data.list_end || (32'(slot_ff) == 32'(BATCH_SIZE - 1)) ||
                     (slot_ff == 8'hFF);
   assign slot_in  = blast_in ? 8'd0 : 8'(slot_ff + 8'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= 8'd0;
      end else if (accept) begin
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NST; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < NST; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff[0][0] <= req_data.pos_x;
         pos_ff[0][1] <= req_data.pos_y;
         pos_ff[0][2] <= req_data.pos_z;
         tan_ff[0]    <= req_data.tan_x;
         tan_ff[1]    <= req_data.tan_y;
         tan_ff[2]    <= req_data.tan_z;
         nrm_ff[0]    <= req_data.nrm_x;
         nrm_ff[1]    <= req_data.nrm_y;
         nrm_ff[2]    <= req_data.nrm_z;
         scl_ff       <= req_data.scale_factor;
         ang_ff       <= req_data.angle & ANGLE_MASK;
         base_ff[0]   <= {slot_ff, 2'b00};
         blast_ff[0]  <= blast_in;
         for (int k = 1; k < NST; k++) begin
            pos_ff[k]   <= pos_ff[k-1];
            base_ff[k]  <= base_ff[k-1];
            blast_ff[k] <= blast_ff[k-1];
         end
         for (int a = 0; a < 3; a++) begin
            // Stage 1: right and up before rotation.
            rgt_ff[1][a] <= SCL_W'(tan_ff[a]) * $signed({17'd0, scl_ff});
            up_ff[1][a]  <= SCL_W'(nrm_ff[a]) * $signed({17'd0, scl_ff});
            for (int k = 2; k <= 4; k++) begin
               rgt_ff[k][a] <= rgt_ff[k-1][a];
               up_ff[k][a]  <= up_ff[k-1][a];
            end
            // Stage 5: the four rotation products.
            rc_ff[a] <= PROD_W'(rgt_ff[4][a]) * PROD_W'(cos_val);
            us_ff[a] <= PROD_W'(up_ff[4][a])  * PROD_W'(sin_val);
            rs_ff[a] <= PROD_W'(rgt_ff[4][a]) * PROD_W'(sin_val);
            uc_ff[a] <= PROD_W'(up_ff[4][a])  * PROD_W'(cos_val);
            // Stage 6: rotated right and up.
            rr_ff[a] <= ROT_W'(rc_ff[a]) - ROT_W'(us_ff[a]);
            ru_ff[a] <= ROT_W'(rs_ff[a]) + ROT_W'(uc_ff[a]);
            // Stage 7: the two offsets that all four corners are built from.
            sum_ff[a] <= CRN_W'(rr_ff[a]) + CRN_W'(ru_ff[a]);
            dif_ff[a] <= CRN_W'(rr_ff[a]) - CRN_W'(ru_ff[a]);
         end
      end
   end

   // Sine and cosine each have their own quarter-wave polynomial, stages 1 to 4.
   // Odd quadrants mirror the argument, the upper half negates the result.
   assign sin_ph = ang_ff;
   assign cos_ph = 16'(ang_ff + QUARTER_TURN);
   assign sin_t  = sin_ph[14] ? 15'(15'd16384 - {1'b0, sin_ph[13:0]}) : {1'b0, sin_ph[13:0]};
   assign cos_t  = cos_ph[14] ? 15'(15'd16384 - {1'b0, cos_ph[13:0]}) : {1'b0, cos_ph[13:0]};

   sqe_qsin u_sin (
      .clock (clock),
      .en    (en),
      .t     (sin_t),
      .neg   (sin_ph[15]),
      .val   (sin_val)
   );

   sqe_qsin u_cos (
      .clock (clock),
      .en    (en),
      .t     (cos_t),
      .neg   (cos_ph[15]),
      .val   (cos_val)
   );

   // Expander: holds one finished sprite and walks through its six results.
   always_ff @(posedge clock) begin
      if (reset) begin
         ex_vld_ff <= 1'b0;
         ex_cnt_ff <= RES_V0;
      end else if (take) begin
         ex_vld_ff <= 1'b1;
         ex_cnt_ff <= RES_V0;
      end else if (ex_done) begin
         ex_vld_ff <= 1'b0;
         ex_cnt_ff <= RES_V0;
      end else if (ex_fire) begin
         ex_cnt_ff <= 3'(ex_cnt_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ex_pos_ff   <= pos_ff[NST-1];
         ex_sum_ff   <= sum_ff;
         ex_dif_ff   <= dif_ff;
         ex_base_ff  <= base_ff[NST-1];
         ex_blast_ff <= blast_ff[NST-1];
      end
   end

   // Corner order: +R-U, +R+U, -R+U, -R-U, that is dif, sum, -dif, -sum.
   always_comb begin
      logic signed [CRN_W-1:0] ofs [0:2];
      rsp_in = '0;
      rsp_in.batch_last = ex_blast_ff;
      for (int a = 0; a < 3; a++) begin
         case (ex_cnt_ff)
            RES_V0:  ofs[a] = ex_dif_ff[a];
            RES_V1:  ofs[a] = ex_sum_ff[a];
            RES_V2:  ofs[a] = -ex_dif_ff[a];
            RES_V3:  ofs[a] = -ex_sum_ff[a];
            default: ofs[a] = '0;
         endcase
      end
      case (ex_cnt_ff)
         RES_V0, RES_V1, RES_V2, RES_V3: begin
            rsp_in.kind  = KIND_VERTEX;
            rsp_in.vx    = corner_f(ex_pos_ff[0], ofs[0]);
            rsp_in.vy    = corner_f(ex_pos_ff[1], ofs[1]);
            rsp_in.vz    = corner_f(ex_pos_ff[2], ofs[2]);
            rsp_in.tex_u = (ex_cnt_ff == RES_V1) || (ex_cnt_ff == RES_V2);
            rsp_in.tex_v = (ex_cnt_ff == RES_V0) || (ex_cnt_ff == RES_V1);
            rsp_in.idx_a = 10'(ex_base_ff + {8'd0, ex_cnt_ff[1:0]});
         end
         RES_T0, RES_T1: begin
            rsp_in.kind  = KIND_TRIANGLE;
            rsp_in.idx_a = ex_base_ff;
            rsp_in.idx_b = 10'(ex_base_ff + ((ex_cnt_ff == RES_T1) ? 10'd2 : 10'd1));
            rsp_in.idx_c = 10'(ex_base_ff + ((ex_cnt_ff == RES_T1) ? 10'd3 : 10'd2));
            rsp_in.last  = (ex_cnt_ff == RES_T1);
         end
         default: begin
            rsp_in.kind = KIND_VERTEX;
         end
      endcase
   end

   // Output register parts the expander from a stalling receiver.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= ex_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ex_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
